>>> hdl/hbw_pkg.sv
// ----------------------------------------------------------------------------
// hbw_pkg - heartbeat watchdog shared definitions
// Word formats, command codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package hbw_pkg;

    localparam int NUM_TASKS  = 16;
    localparam int MASK_W     = 16;
    localparam int AGE_W      = 8;
    localparam int TASK_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MASK_W-1:0] WATCH_MASK_RST  = MASK_W'(1);
    localparam logic [AGE_W-1:0]  WARN_TICKS_RST  = AGE_W'(10);
    localparam logic [AGE_W-1:0]  RESET_TICKS_RST = AGE_W'(13);
    localparam logic [AGE_W-1:0]  AGE_MAX         = '1;

    typedef enum logic [1:0] {
        CMD_TICK        = 2'd0,
        CMD_CHECKIN     = 2'd1,
        CMD_CHECKIN_ALL = 2'd2,
        CMD_ELAPSED     = 2'd3
    } hbw_cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WATCH_MASK  = 2'd0,
        CFG_WARN_TICKS  = 2'd1,
        CFG_RESET_TICKS = 2'd2,
        CFG_UNUSED      = 2'd3
    } hbw_cfg_idx_t;

    typedef struct packed {
        hbw_cmd_t          cmd;
        logic [TASK_W-1:0] task_req;
        logic [AGE_W-1:0]  elapsed_ticks;
    } hbw_item_t;

    typedef struct packed {
        logic              fed;
        logic              recovered;
        logic              warning;
        logic              force_reset;
        logic [MASK_W-1:0] stuck_tasks;
        logic [AGE_W-1:0]  ticks_since_feed;
    } hbw_result_t;

    typedef struct packed {
        logic                  we;
        hbw_cfg_idx_t          index;
        logic [CFG_DATA_W-1:0] wdata;
    } hbw_cfg_t;

endpackage

>>> hdl/hbw_in_reg.sv
// ----------------------------------------------------------------------------
// hbw_in_reg - input word register
// Captures one command word and holds it until the core takes it.
// ----------------------------------------------------------------------------
module hbw_in_reg import hbw_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  hbw_item_t in_item,
    output logic      out_valid,
    input  logic      out_take,
    output hbw_item_t out_item
);

    logic      valid_reg;
    hbw_item_t item_reg;

    assign in_ready  = !valid_reg || out_take;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

endmodule

>>> hdl/hbw_core.sv
// ----------------------------------------------------------------------------
// hbw_core - heartbeat evaluation
// Holds config and watchdog state; updates both and forms one result per word.
// ----------------------------------------------------------------------------
module hbw_core import hbw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  hbw_cfg_t    cfg,
    input  logic        step,
    input  hbw_item_t   item,
    output hbw_result_t result
);

    logic [MASK_W-1:0] watch_mask_reg, checkin_bits_reg, checkin_bits_next;
    logic [AGE_W-1:0]  warn_ticks_reg, reset_ticks_reg;
    logic [AGE_W-1:0]  feed_age_reg, feed_age_next;
    logic [AGE_W-1:0]  last_warn_reg, last_warn_next;

    logic [AGE_W:0]    age_sum;
    logic [AGE_W-1:0]  age_add, age_adv;
    logic [MASK_W-1:0] task_bit, stuck;
    logic              fed, recovered, warning, force_rst;

    always_comb begin
        task_bit = '0;
        if (32'(item.task_req) < NUM_TASKS && 32'(item.task_req) < MASK_W) begin
            task_bit[item.task_req] = 1'b1;
        end

        age_add = (item.cmd == CMD_TICK) ? AGE_W'(1) : item.elapsed_ticks;
        age_sum = {1'b0, feed_age_reg} + {1'b0, age_add};
        age_adv = age_sum[AGE_W] ? AGE_MAX : age_sum[AGE_W-1:0];

        checkin_bits_next = checkin_bits_reg;
        feed_age_next     = feed_age_reg;
        last_warn_next    = last_warn_reg;
        fed               = 1'b0;
        recovered         = 1'b0;
        warning           = 1'b0;
        force_rst         = 1'b0;
        stuck             = watch_mask_reg & ~checkin_bits_reg;

        unique case (item.cmd) inside
            CMD_CHECKIN, CMD_CHECKIN_ALL: begin
                checkin_bits_next = checkin_bits_reg |
                    ((item.cmd == CMD_CHECKIN) ? task_bit : watch_mask_reg);
                stuck = watch_mask_reg & ~checkin_bits_next;
            end
            default: begin
                feed_age_next = age_adv;
                if (stuck == '0) begin
                    checkin_bits_next = '0;
                    feed_age_next     = '0;
                    fed               = 1'b1;
                    if (last_warn_reg != '0) begin
                        recovered      = 1'b1;
                        last_warn_next = '0;
                    end
                end
                if (feed_age_next >= warn_ticks_reg && feed_age_next > last_warn_next) begin
                    warning        = 1'b1;
                    force_rst      = (feed_age_next >= reset_ticks_reg);
                    last_warn_next = feed_age_next;
                end
            end
        endcase

        result.fed              = fed;
        result.recovered        = recovered;
        result.warning          = warning;
        result.force_reset      = force_rst;
        result.stuck_tasks      = stuck;
        result.ticks_since_feed = feed_age_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            watch_mask_reg   <= WATCH_MASK_RST;
            warn_ticks_reg   <= WARN_TICKS_RST;
            reset_ticks_reg  <= RESET_TICKS_RST;
            checkin_bits_reg <= '0;
            feed_age_reg     <= '0;
            last_warn_reg    <= '0;
        end else begin
            if (cfg.we) begin
                unique case (cfg.index)
                    CFG_WATCH_MASK:  watch_mask_reg  <= cfg.wdata[MASK_W-1:0];
                    CFG_WARN_TICKS:  warn_ticks_reg  <= cfg.wdata[AGE_W-1:0];
                    CFG_RESET_TICKS: reset_ticks_reg <= cfg.wdata[AGE_W-1:0];
                    default: ;
                endcase
            end
            if (step) begin
                checkin_bits_reg <= checkin_bits_next;
                feed_age_reg     <= feed_age_next;
                last_warn_reg    <= last_warn_next;
            end
        end
    end

endmodule

>>> hdl/hbw_out_reg.sv
// ----------------------------------------------------------------------------
// hbw_out_reg - result word register
// Holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module hbw_out_reg import hbw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  hbw_result_t in_res,
    output logic        out_valid,
    input  logic        out_ready,
    output hbw_result_t out_res
);

    logic        valid_reg;
    hbw_result_t res_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            res_reg <= in_res;
        end
    end

endmodule

>>> hdl/task_heartbeat_watchdog.sv
// ----------------------------------------------------------------------------
// task_heartbeat_watchdog - multi-task heartbeat watchdog
// Tracks task check-ins and tick counts, feeds, warns and forces reset.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries command words (tick, task check-in, check-in all, elapsed
//   sleep ticks); m_* returns exactly one result word per command word.
//   cfg_we/cfg_index/cfg_wdata writes watch_mask (0), warn_ticks (1) and
//   reset_ticks (2); write only while no word is in flight.
//   Path: a word in the input register is evaluated and its result taken into
//   the result register, held on m_*; two register stages (input, result).
//   Throughput: one word per cycle while m_ready is high; the evaluation is a
//   single pass of logic between the input register and the result register.
//   Reset: registers return to watch_mask 1, warn 10, reset 13, with no
//   check-ins, a zero count and no pending warning. Both stages empty.
//   Stall: while m_ready is low the result word holds; the input register
//   still fills, and s_ready drops only once both stages are occupied.
// ----------------------------------------------------------------------------
module task_heartbeat_watchdog import hbw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // command words
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_cmd,
    input  logic [TASK_W-1:0]     s_task_req,
    input  logic [AGE_W-1:0]      s_elapsed_ticks,
    // result words
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_fed,
    output logic                  m_recovered,
    output logic                  m_warning,
    output logic                  m_force_reset,
    output logic [MASK_W-1:0]     m_stuck_tasks,
    output logic [AGE_W-1:0]      m_ticks_since_feed
);

    hbw_item_t   s_item, core_item;
    hbw_result_t core_res, m_res;
    hbw_cfg_t    cfg;
    logic        core_valid, res_ready, step;

    assign s_item.cmd           = hbw_cmd_t'(s_cmd);
    assign s_item.task_req      = s_task_req;
    assign s_item.elapsed_ticks = s_elapsed_ticks;

    assign cfg.we    = cfg_we;
    assign cfg.index = hbw_cfg_idx_t'(cfg_index);
    assign cfg.wdata = cfg_wdata;

    // the core commits state exactly when the result register takes its word
    assign step = core_valid && res_ready;

    hbw_in_reg u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_item  (s_item),
        .out_valid(core_valid),
        .out_take (res_ready),
        .out_item (core_item)
    );

    hbw_core u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cfg    (cfg),
        .step   (step),
        .item   (core_item),
        .result (core_res)
    );

    hbw_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (core_valid),
        .in_ready (res_ready),
        .in_res   (core_res),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_res  (m_res)
    );

    assign m_fed              = m_res.fed;
    assign m_recovered        = m_res.recovered;
    assign m_warning          = m_res.warning;
    assign m_force_reset      = m_res.force_reset;
    assign m_stuck_tasks      = m_res.stuck_tasks;
    assign m_ticks_since_feed = m_res.ticks_since_feed;

    // a feed clears the count, so it can never warn in the same word
    a_feed_no_warn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_fed && m_warning))
        else $error("feed and warning in one word");

    // forced reset is only raised alongside a warning
    a_force_needs_warn: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_force_reset) |-> m_warning)
        else $error("force_reset without warning");

    // a feed means nothing watched was stuck and the count restarted
    a_feed_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_fed) |-> (m_stuck_tasks == '0 && m_ticks_since_feed == '0))
        else $error("feed with stuck tasks or nonzero count");

    // recovery is only reported on a feed
    a_recover_on_feed: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_recovered) |-> m_fed)
        else $error("recovered without feed");

endmodule
